// ----- hdl/rwng_pkg.sv -----
// ----------------------------------------------------------------------------
// rwng_pkg
// Shared constants and types for the random walk noise generator.
// ----------------------------------------------------------------------------
package rwng_pkg;

    localparam int INSTANCES = 32;
    localparam int INST_W    = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;

    localparam logic [31:0] LCG_MUL      = 32'd1664525;
    localparam logic [31:0] LCG_ADD      = 32'd1013904223;
    localparam logic [31:0] TWO_PI_Q29   = 32'd3373259426;
    localparam logic [18:0] DEFAULT_RATE = 19'd44100;
    localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
    localparam logic [30:0] EXP_K6       = 31'd213044;

    // Horner coefficients of exp(-u), highest order first, then the constant term
    localparam logic [30:0] HORNER_K [7] = '{
        31'd1491308, 31'd8947849, 31'd44739243, 31'd178956971,
        31'd536870912, 31'd1073741824, 31'd1073741824
    };

    typedef enum logic [1:0] {
        MODE_WHITE = 2'd0,
        MODE_LOWPASS = 2'd1,
        MODE_SCALED_WALK = 2'd2,
        MODE_SIGN_WALK = 2'd3
    } mode_t;

    typedef struct packed {
        logic [31:0]        key;
        logic [31:0]        lcg;
        logic signed [31:0] walk;
        logic signed [31:0] filt;
    } entry_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD, ST_LCG,
        ST_POLE_MUL, ST_POLE_DIV, ST_POLE_WAIT,
        ST_HORNER_MUL, ST_HORNER_ADD, ST_SQ_MUL, ST_SQ_ADD,
        ST_INC_DIV, ST_INC_WAIT, ST_JIT_DIV, ST_JIT_WAIT,
        ST_CU_DIV, ST_CU_WAIT, ST_CD_DIV, ST_CD_WAIT,
        ST_WALK, ST_WALK_ADD,
        ST_MIX_MUL, ST_MIX_ACC, ST_MIX_ADD,
        ST_LP_MUL, ST_LP_ACC, ST_LP_ADD,
        ST_FIN_MUL, ST_FIN_ADD
    } state_t;

endpackage

// ----- hdl/rwng_state_mem.sv -----
// ----------------------------------------------------------------------------
// rwng_state_mem
// Per-instance state memory, one read and one write port, registered read.
// ----------------------------------------------------------------------------
module rwng_state_mem
    import rwng_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [INST_W-1:0] rd_addr,
    output entry_t            rd_data,
    output logic              rd_seeded,
    input  logic              wr_en,
    input  logic [INST_W-1:0] wr_addr,
    input  entry_t            wr_data
);

    entry_t                 mem [INSTANCES];
    entry_t                 rd_data_reg;
    logic                   rd_seeded_reg;
    logic [INSTANCES-1:0]   seeded_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg    <= '0;
            rd_seeded_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                seeded_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_seeded_reg <= seeded_reg[rd_addr];
            end
        end
    end

    assign rd_data   = rd_data_reg;
    assign rd_seeded = rd_seeded_reg;

endmodule

// ----- hdl/rwng_mul.sv -----
// ----------------------------------------------------------------------------
// rwng_mul
// Shared signed 33x33 multiplier with registered product.
// ----------------------------------------------------------------------------
module rwng_mul
    import rwng_pkg::*;
(
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] prod
);

    logic signed [65:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ----- hdl/rwng_div.sv -----
// ----------------------------------------------------------------------------
// rwng_div
// Restoring divider, one quotient bit per cycle, 32-bit quotient.
// ----------------------------------------------------------------------------
module rwng_div
    import rwng_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [71:0] dividend,
    input  logic [39:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [39:0] rem_reg, rem_next;
    logic [31:0] dvd_reg, dvd_next;
    logic [39:0] den_reg, den_next;
    logic [31:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [40:0] trial;
    logic        ge;

    // upper dividend bits are below the divisor, so the quotient fits 32 bits
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[31]};
        ge        = trial >= {1'b0, den_reg};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend[71:32];
            dvd_next  = dividend[31:0];
            den_next  = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 40'(trial - {1'b0, den_reg}) : trial[39:0];
            dvd_next = {dvd_reg[30:0], 1'b0};
            q_next   = {q_reg[30:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- hdl/random_walk_noise_generator_top.sv -----
// ----------------------------------------------------------------------------
// random_walk_noise_generator_top
// Multi-instance LCG noise / random walk source with one-pole lowpass.
// ----------------------------------------------------------------------------
// One sample per transaction; the block works on one transaction at a time and
// holds in_stall high until its result is in the output register. Divisions
// use the shared 32-bit restoring divider and products the shared multiplier.
// White mode needs neither the pole nor the walk steps, lowpass mode skips the
// walk steps, and the walk modes skip a division when a rate saturates or the
// white mix is zero. A finished result waits out any output stall. Instances
// whose index is out of range return 0 and leave state untouched. Per-instance
// state sits in a synchronous memory read at the start and written back at the
// end of each transaction; no clearing pass is needed after reset.
module random_walk_noise_generator_top
    import rwng_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [18:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [4:0]         instance_req,
    input  logic [1:0]         mode,
    input  logic [23:0]        cutoff_hz,
    input  logic [23:0]        jitter_hz,
    input  logic signed [15:0] gain,
    input  logic [31:0]        seed_key,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] sample
);

    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [23:0]        cutoff_reg, cutoff_next;
    logic [23:0]        jitter_reg, jitter_next;
    logic signed [15:0] gain_reg, gain_next;
    logic [31:0]        key_reg, key_next;
    logic [INST_W-1:0]  idx_reg, idx_next;
    logic               oor_reg, oor_next;
    logic [31:0]        lcg_reg, lcg_next;
    logic signed [31:0] walk_reg, walk_next;
    logic signed [31:0] filt_reg, filt_next;
    logic signed [31:0] fin_reg, fin_next;
    logic [30:0]        u_reg, u_next;
    logic [30:0]        h_reg, h_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [30:0]        inc_reg, inc_next;
    logic [30:0]        jit_reg, jit_next;
    logic [30:0]        step_reg, step_next;
    logic [30:0]        wmix_reg, wmix_next;
    logic signed [65:0] acc_reg, acc_next;
    logic [18:0]        rate_reg;
    logic               out_valid_reg, out_valid_next;
    logic signed [23:0] sample_reg, sample_next;

    logic               accept;
    logic               rd_seeded;
    entry_t             rd_data;
    logic               wr_en;
    entry_t             wr_data;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic               div_start;
    logic [71:0]        div_dividend;
    logic [39:0]        div_divisor;
    logic               div_done;
    logic [31:0]        div_q;

    logic [18:0]        rate_eff, rate_min;
    logic [26:0]        rate_den;
    logic               init;
    logic [31:0]        lcg0;
    logic [31:0]        seed;
    logic signed [31:0] n31, n30;
    logic [61:0]        sq_sum;
    logic [31:0]        step_sum;
    logic [33:0]        avg5;
    logic [30:0]        t_cd;
    logic signed [33:0] walk_sum;
    logic signed [65:0] wsum, rsum, rnd;
    logic signed [31:0] walk_clamp;
    logic signed [23:0] sat_val;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = state_reg != ST_IDLE;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    rwng_state_mem u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr   (INST_W'(instance_req)),
        .rd_data   (rd_data),
        .rd_seeded (rd_seeded),
        .wr_en     (wr_en),
        .wr_addr   (idx_reg),
        .wr_data   (wr_data)
    );

    rwng_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    rwng_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign wr_data = '{key: key_reg, lcg: lcg_reg, walk: walk_reg, filt: filt_reg};

    always_comb
    begin
        rate_eff = (rate_reg == '0) ? DEFAULT_RATE : rate_reg;
        rate_min = (rate_eff < DEFAULT_RATE) ? DEFAULT_RATE : rate_eff;
        rate_den = {rate_eff, 8'd0};
        init     = !rd_seeded || (rd_data.key != key_reg);
        lcg0     = init ? key_reg : rd_data.lcg;
        seed     = prod[31:0] + LCG_ADD;
        n31      = {~lcg_reg[31], lcg_reg[30:0]};
        n30      = n31 >>> 1;
        sq_sum   = prod[61:0] + 62'(ONE_Q30 >> 1);
        step_sum = {1'b0, inc_reg} + {1'b0, div_q[30:0]};
        avg5     = 34'd5 * ({3'd0, inc_reg} + {3'd0, jit_reg});
        t_cd     = 31'(avg5 - 34'd9 * 34'(ONE_Q30));
        wsum     = (prod + 66'sd1073741824) >>> 31;
        if (mode_reg == MODE_SIGN_WALK)
        begin
            walk_sum = lcg_reg[31] ? 34'(walk_reg) + 34'(signed'({1'b0, step_reg}))
                                   : 34'(walk_reg) - 34'(signed'({1'b0, step_reg}));
        end
        else
        begin
            walk_sum = 34'(walk_reg) + 34'(wsum);
        end
        if (walk_sum > 34'sd1073741824)
        begin
            walk_clamp = 32'sd1073741824;
        end
        else if (walk_sum < -34'sd1073741824)
        begin
            walk_clamp = -32'sd1073741824;
        end
        else
        begin
            walk_clamp = 32'(walk_sum);
        end
        rsum = (acc_reg + prod + 66'sd536870912) >>> 30;
        // white mode rounds Q1.31*Q2.14 to Q2.22, filtered modes Q1.30*Q2.14
        if (mode_reg == MODE_WHITE)
        begin
            rnd = (prod + 66'sd4194304) >>> 23;
        end
        else
        begin
            rnd = (prod + 66'sd2097152) >>> 22;
        end
        if (rnd > 66'sd8388607)
        begin
            sat_val = 24'sd8388607;
        end
        else if (rnd < -66'sd8388608)
        begin
            sat_val = -24'sd8388608;
        end
        else
        begin
            sat_val = 24'(rnd);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        cutoff_next    = cutoff_reg;
        jitter_next    = jitter_reg;
        gain_next      = gain_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        oor_next       = oor_reg;
        lcg_next       = lcg_reg;
        walk_next      = walk_reg;
        filt_next      = filt_reg;
        fin_next       = fin_reg;
        u_next         = u_reg;
        h_next         = h_reg;
        cnt_next       = cnt_reg;
        inc_next       = inc_reg;
        jit_next       = jit_reg;
        step_next      = step_reg;
        wmix_next      = wmix_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        sample_next    = sample_reg;
        wr_en          = 1'b0;
        mul_a          = 33'(fin_reg);
        mul_b          = 33'(gain_reg);
        div_start      = 1'b0;
        div_dividend   = {18'd0, cutoff_reg, 30'd0};
        div_divisor    = 40'(rate_den);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next   = mode_t'(mode);
                    cutoff_next = cutoff_hz;
                    jitter_next = jitter_hz;
                    gain_next   = gain;
                    key_next    = seed_key;
                    idx_next    = INST_W'(instance_req);
                    oor_next    = 32'(instance_req) >= INSTANCES;
                    state_next  = (32'(instance_req) >= INSTANCES) ? ST_FIN_ADD : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                walk_next  = init ? '0 : rd_data.walk;
                filt_next  = init ? '0 : rd_data.filt;
                mul_a      = {1'b0, lcg0};
                mul_b      = {1'b0, LCG_MUL};
                state_next = ST_LCG;
            end
            ST_LCG:
            begin
                lcg_next   = seed;
                fin_next   = {~seed[31], seed[30:0]};
                state_next = (mode_reg == MODE_WHITE) ? ST_FIN_MUL : ST_POLE_MUL;
            end
            ST_POLE_MUL:
            begin
                mul_a      = 33'(cutoff_reg);
                mul_b      = {1'b0, TWO_PI_Q29};
                state_next = ST_POLE_DIV;
            end
            ST_POLE_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = {16'd0, prod[55:0]};
                div_divisor  = {9'd0, rate_min, 12'd0};
                state_next   = ST_POLE_WAIT;
            end
            ST_POLE_WAIT:
            begin
                if (div_done)
                begin
                    u_next     = div_q[30:0];
                    h_next     = EXP_K6;
                    cnt_next   = '0;
                    state_next = ST_HORNER_MUL;
                end
            end
            ST_HORNER_MUL:
            begin
                mul_a      = {2'd0, u_reg};
                mul_b      = {2'd0, h_reg};
                state_next = ST_HORNER_ADD;
            end
            ST_HORNER_ADD:
            begin
                h_next = HORNER_K[cnt_reg] - prod[60:30];
                if (cnt_reg == 3'd6)
                begin
                    cnt_next   = '0;
                    state_next = ST_SQ_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg + 3'd1;
                    state_next = ST_HORNER_MUL;
                end
            end
            ST_SQ_MUL:
            begin
                mul_a      = {2'd0, h_reg};
                mul_b      = {2'd0, h_reg};
                state_next = ST_SQ_ADD;
            end
            ST_SQ_ADD:
            begin
                // exp(-w/32) squared five times; h_reg then holds a1
                h_next = sq_sum[60:30];
                if (cnt_reg == 3'd4)
                begin
                    if (mode_reg == MODE_LOWPASS)
                    begin
                        fin_next   = n30;
                        state_next = ST_LP_MUL;
                    end
                    else
                    begin
                        state_next = ST_INC_DIV;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + 3'd1;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_INC_DIV:
            begin
                if (27'(cutoff_reg) >= rate_den)
                begin
                    inc_next   = ONE_Q30;
                    state_next = ST_JIT_DIV;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_INC_WAIT;
                end
            end
            ST_INC_WAIT:
            begin
                if (div_done)
                begin
                    inc_next   = div_q[30:0];
                    state_next = ST_JIT_DIV;
                end
            end
            ST_JIT_DIV:
            begin
                div_dividend = {18'd0, jitter_reg, 30'd0};
                if (27'(jitter_reg) >= rate_den)
                begin
                    jit_next   = ONE_Q30;
                    state_next = ST_CU_DIV;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_JIT_WAIT;
                end
            end
            ST_JIT_WAIT:
            begin
                if (div_done)
                begin
                    jit_next   = div_q[30:0];
                    state_next = ST_CU_DIV;
                end
            end
            ST_CU_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = {38'(39'd199 * 39'(jit_reg)), 34'd0} >> 4;
                div_divisor  = 40'(ONE_Q30) + 40'd198 * 40'(jit_reg);
                state_next   = ST_CU_WAIT;
            end
            ST_CU_WAIT:
            begin
                if (div_done)
                begin
                    step_next = (step_sum > 32'(ONE_Q30)) ? ONE_Q30 : step_sum[30:0];
                    if (avg5 >= 34'd9 * 34'(ONE_Q30))
                    begin
                        state_next = ST_CD_DIV;
                    end
                    else
                    begin
                        wmix_next  = '0;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_CD_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = {36'(36'd3 * 36'(t_cd)), 36'd0} >> 6;
                div_divisor  = 40'd17 * 40'(ONE_Q30) - 40'd14 * 40'(t_cd);
                state_next   = ST_CD_WAIT;
            end
            ST_CD_WAIT:
            begin
                if (div_done)
                begin
                    wmix_next  = div_q[30:0];
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                mul_a = 33'(n31);
                mul_b = {2'd0, step_reg};
                if (mode_reg == MODE_SIGN_WALK)
                begin
                    walk_next  = walk_clamp;
                    state_next = ST_MIX_MUL;
                end
                else
                begin
                    state_next = ST_WALK_ADD;
                end
            end
            ST_WALK_ADD:
            begin
                walk_next  = walk_clamp;
                state_next = ST_MIX_MUL;
            end
            ST_MIX_MUL:
            begin
                mul_a      = 33'(walk_reg);
                mul_b      = {2'd0, 31'(ONE_Q30 - wmix_reg)};
                state_next = ST_MIX_ACC;
            end
            ST_MIX_ACC:
            begin
                acc_next   = prod;
                mul_a      = 33'(n30);
                mul_b      = {2'd0, wmix_reg};
                state_next = ST_MIX_ADD;
            end
            ST_MIX_ADD:
            begin
                fin_next   = 32'(rsum);
                state_next = ST_LP_MUL;
            end
            ST_LP_MUL:
            begin
                mul_a      = {2'd0, 31'(ONE_Q30 - h_reg)};
                mul_b      = 33'(fin_reg);
                state_next = ST_LP_ACC;
            end
            ST_LP_ACC:
            begin
                acc_next   = prod;
                mul_a      = {2'd0, h_reg};
                mul_b      = 33'(filt_reg);
                state_next = ST_LP_ADD;
            end
            ST_LP_ADD:
            begin
                filt_next  = 32'(rsum);
                fin_next   = 32'(rsum);
                state_next = ST_FIN_MUL;
            end
            ST_FIN_MUL:
            begin
                state_next = ST_FIN_ADD;
            end
            ST_FIN_ADD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    sample_next    = oor_reg ? '0 : sat_val;
                    wr_en          = !oor_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        cutoff_reg <= cutoff_next;
        jitter_reg <= jitter_next;
        gain_reg   <= gain_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        oor_reg    <= oor_next;
        lcg_reg    <= lcg_next;
        walk_reg   <= walk_next;
        filt_reg   <= filt_next;
        fin_reg    <= fin_next;
        u_reg      <= u_next;
        h_reg      <= h_next;
        inc_reg    <= inc_next;
        jit_reg    <= jit_next;
        step_reg   <= step_next;
        wmix_reg   <= wmix_next;
        acc_reg    <= acc_next;
        sample_reg <= sample_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            rate_reg      <= DEFAULT_RATE;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                rate_reg <= cfg_data;
            end
        end
    end

endmodule

// ----- hdl/rwng_checker.sv -----
// ----------------------------------------------------------------------------
// rwng_checker
// Port-level checks for the random walk noise generator.
// ----------------------------------------------------------------------------
module rwng_checker
    import rwng_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [23:0] sample
);

    // a stalled input transaction stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("input valid dropped while stalled");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample))
        else $error("result changed while stalled");

    // one transaction at a time: accepting one closes the input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction taken while busy");

    // a new result only comes out of a busy block
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a transaction in flight");

endmodule

bind random_walk_noise_generator_top rwng_checker u_rwng_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample)
);

// ----- bench/tb_random_walk_noise_generator_top.sv -----
// ----------------------------------------------------------------------------
// tb_random_walk_noise_generator_top
// Self-checking bench for the random walk noise generator: a directed table of
// corner cases, then random traffic over several sample rates. Each accepted
// transaction runs through a bit-accurate predictor with its own per-instance
// state. The expected samples are queued and compared with the DUT output.
// ----------------------------------------------------------------------------
module tb_random_walk_noise_generator_top
    import rwng_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_ITEMS = 900;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  DRAIN_CYCLES = 250;
    localparam int  NUM_DIRECTED = 16;
    localparam longint ONE       = 64'sd1 << 30;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [18:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [4:0]         instance_req;
    logic [1:0]         mode;
    logic [23:0]        cutoff_hz;
    logic [23:0]        jitter_hz;
    logic signed [15:0] gain;
    logic [31:0]        seed_key;
    logic               out_valid;
    logic               out_stall;
    logic signed [23:0] sample;

    random_walk_noise_generator_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .instance_req (instance_req),
        .mode         (mode),
        .cutoff_hz    (cutoff_hz),
        .jitter_hz    (jitter_hz),
        .gain         (gain),
        .seed_key     (seed_key),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample       (sample)
    );

    // predictor state
    bit                 inst_seeded [INSTANCES];
    bit [31:0]          inst_key    [INSTANCES];
    bit [31:0]          inst_lcg    [INSTANCES];
    longint             inst_walk   [INSTANCES];
    longint             inst_filt   [INSTANCES];
    bit [18:0]          rate_reg;

    logic signed [23:0] expected_samples [$];
    int                 mismatches;
    int                 cycles;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    bit [31:0]          stim_keys [INSTANCES];

    typedef struct {
        int                 inst;
        mode_t              md;
        bit [23:0]          cut;
        bit [23:0]          jit;
        bit signed [15:0]   g;
        bit [31:0]          key;
        bit                 known;
        bit signed [23:0]   want;
    } stim_row_t;

    stim_row_t dir_rows [NUM_DIRECTED] = '{
        '{0,  MODE_WHITE,        24'd0,        24'd0,        16'sd16384,  32'd0,
          1'b1, -24'sd2214022},
        '{1,  MODE_WHITE,        24'd0,        24'd0,        16'sd0,      32'hFFFF_FFFF,
          1'b1, 24'sd0},
        '{1,  MODE_WHITE,        24'd0,        24'd0,        -16'sd32768, 32'hFFFF_FFFF,
          1'b0, 24'sd0},
        '{1,  MODE_WHITE,        24'hFFFFFF,   24'hFFFFFF,   16'sd32767,  32'hFFFF_FFFF,
          1'b0, 24'sd0},
        '{2,  MODE_LOWPASS,      24'd0,        24'd0,        16'sd16384,  32'd1,
          1'b0, 24'sd0},
        '{2,  MODE_LOWPASS,      24'hFFFFFF,   24'd0,        16'sd32767,  32'd1,
          1'b0, 24'sd0},
        '{2,  MODE_LOWPASS,      24'd256000,   24'd0,        -16'sd32768, 32'd1,
          1'b0, 24'sd0},
        '{3,  MODE_SCALED_WALK,  24'd128000,   24'd12800,    16'sd16384,  32'd5,
          1'b0, 24'sd0},
        '{3,  MODE_SCALED_WALK,  24'hFFFFFF,   24'hFFFFFF,   16'sd32767,  32'd5,
          1'b0, 24'sd0},
        '{4,  MODE_SIGN_WALK,    24'd25600,    24'd0,        16'sd16384,  32'd7,
          1'b0, 24'sd0},
        '{4,  MODE_SIGN_WALK,    24'd0,        24'hFFFFFF,   16'sd16384,  32'd7,
          1'b0, 24'sd0},
        '{4,  MODE_SIGN_WALK,    24'hFFFFFF,   24'hFFFFFF,   -16'sd32768, 32'd7,
          1'b0, 24'sd0},
        '{4,  MODE_SIGN_WALK,    24'd25600,    24'd0,        16'sd16384,  32'd8,
          1'b0, 24'sd0},
        '{31, MODE_SCALED_WALK,  24'd0,        24'd0,        16'sd0,      32'h8000_0000,
          1'b1, 24'sd0},
        '{31, MODE_LOWPASS,      24'd512000,   24'd768000,   16'sd16384,  32'h8000_0000,
          1'b0, 24'sd0},
        '{0,  MODE_WHITE,        24'd0,        24'd0,        -16'sd1,     32'd0,
          1'b0, 24'sd0}
    };

    // ---------------------------------------------------------------- predictor

    function automatic longint unsigned frac_q30(longint unsigned num,
                                                 longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = num / den;
        r = num % den;
        for (int i = 0; i < 30; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    function automatic longint hz_to_rate(longint unsigned hz256, longint unsigned fs);
        longint unsigned den;
        den = fs * 256;
        if (hz256 >= den)
            return ONE;
        return longint'(frac_q30(hz256, den));
    endfunction

    function automatic longint decay_coef(longint unsigned cut, longint unsigned fs);
        longint unsigned taylor [7];
        longint unsigned r;
        longint unsigned u;
        longint unsigned h;
        longint unsigned t;
        taylor = '{64'd1073741824, 64'd536870912, 64'd178956971, 64'd44739243,
                   64'd8947849, 64'd1491308, 64'd213044};
        r = (fs < 64'd44100) ? 64'd44100 : fs;
        u = (cut * 64'(TWO_PI_Q29)) / (64'd4096 * r);
        h = taylor[6];
        for (int i = 5; i >= 0; i--)
            h = taylor[i] - ((u * h) >> 30);
        t = 64'd1073741824 - ((u * h) >> 30);
        for (int i = 0; i < 5; i++)
            t = (t * t + (64'd1 << 29)) >> 30;
        return longint'(t);
    endfunction

    function automatic logic signed [23:0] to_sample(longint v, int s);
        longint r;
        r = (v + (64'sd1 <<< (s - 1))) >>> s;
        if (r > 64'sd8388607)
            r = 64'sd8388607;
        if (r < -64'sd8388608)
            r = -64'sd8388608;
        return r[23:0];
    endfunction

    function automatic longint smooth(int k, longint x, longint a1);
        longint lp;
        lp = ((ONE - a1) * x + a1 * inst_filt[k] + (64'sd1 <<< 29)) >>> 30;
        inst_filt[k] = lp;
        return lp;
    endfunction

    function automatic logic signed [23:0] predict_sample(int k, mode_t md,
            bit [23:0] cut, bit [23:0] jt, bit signed [15:0] g, bit [31:0] key);
        longint unsigned fs;
        longint unsigned ju;
        bit [31:0] nxt;
        longint n31, n30, inc, jit, step, wmix, a1, lp, walk, mixed, gl, avg;
        fs = (rate_reg == 0) ? 64'd44100 : longint'(rate_reg);
        gl = longint'(g);
        if (!inst_seeded[k] || inst_key[k] != key)
        begin
            inst_seeded[k] = 1'b1;
            inst_key[k]    = key;
            inst_lcg[k]    = key;
            inst_walk[k]   = 0;
            inst_filt[k]   = 0;
        end
        nxt = inst_lcg[k] * LCG_MUL + LCG_ADD;
        inst_lcg[k] = nxt;
        n31 = longint'(nxt) - (64'sd1 <<< 31);
        n30 = n31 >>> 1;
        if (md == MODE_WHITE)
            return to_sample(n31 * gl, 23);
        a1 = decay_coef(64'(cut), fs);
        if (md == MODE_LOWPASS)
        begin
            lp = smooth(k, n30, a1);
            return to_sample(lp * gl, 22);
        end
        inc = hz_to_rate(64'(cut), fs);
        jit = hz_to_rate(64'(jt), fs);
        ju = longint'(jit);
        step = inc + longint'(frac_q30(64'd199 * ju, 64'd1073741824 + 64'd198 * ju));
        if (step > ONE)
            step = ONE;
        wmix = 0;
        avg = 5 * (inc + jit);
        if (avg >= 9 * ONE)
        begin
            ju = longint'(avg - 9 * ONE);
            wmix = longint'(frac_q30(64'd3 * ju, 64'd17 * 64'd1073741824 - 64'd14 * ju));
        end
        if (md == MODE_SIGN_WALK)
            walk = inst_walk[k] + ((nxt >= 32'h8000_0000) ? step : -step);
        else
            walk = inst_walk[k] + ((n31 * step + (64'sd1 <<< 30)) >>> 31);
        if (walk > ONE)
            walk = ONE;
        if (walk < -ONE)
            walk = -ONE;
        inst_walk[k] = walk;
        mixed = (walk * (ONE - wmix) + n30 * wmix + (64'sd1 <<< 29)) >>> 30;
        lp = smooth(k, mixed, a1);
        return to_sample(lp * gl, 22);
    endfunction

    // ---------------------------------------------------------------- drivers

    // valid stays up after acceptance; wait_drained drops it, the next call only while it idles
    task automatic send_sample(int k, mode_t md, bit [23:0] cut, bit [23:0] jt,
                               bit signed [15:0] g, bit [31:0] key,
                               bit known, bit signed [23:0] want);
        bit ok;
        logic signed [23:0] pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        instance_req <= k[4:0];
        mode         <= md;
        cutoff_hz    <= cut;
        jitter_hz    <= jt;
        gain         <= g;
        seed_key     <= key;
        do
        begin
            @(negedge clk);
            ok = !in_stall;
            @(posedge clk);
        end
        while (!ok);
        pred = predict_sample(k, md, cut, jt, g, key);
        expected_samples.push_back(known ? want : pred);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_rate(bit [18:0] value);
        bit ok;
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            ok = cfg_ready;
            @(posedge clk);
        end
        while (!ok);
        cfg_valid <= 1'b0;
        rate_reg = value;
    endtask

    function automatic bit [23:0] pick_hz();
        longint unsigned fs;
        longint unsigned v;
        fs = (rate_reg == 0) ? 64'd44100 : longint'(rate_reg);
        case ($urandom_range(3))
            0: v = $urandom_range(24'hFFFFFF);
            1: v = $urandom_range(20000 * 256);
            2: v = $urandom_range(2000);
            default: v = fs * 256 * $urandom_range(80, 110) / 100;
        endcase
        return (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
    endfunction

    task automatic send_random();
        int k;
        bit signed [15:0] g;
        k = $urandom_range(INSTANCES - 1);
        if ($urandom_range(99) < 8)
            stim_keys[k] = $urandom;
        case ($urandom_range(9))
            0: g = 16'sh7FFF;
            1: g = 16'sh8000;
            default: g = 16'($urandom);
        endcase
        send_sample(k, mode_t'($urandom_range(3)), pick_hz(), pick_hz(), g,
                    stim_keys[k], 1'b0, 24'sd0);
    endtask

    // ---------------------------------------------------------------- clock, receiver, checker

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sample %0d", sample);
            end
            else
            begin
                logic signed [23:0] want;
                want = expected_samples.pop_front();
                if (sample !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sample mismatch: expected %0d, got %0d", want, sample);
                end
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        bit [18:0] rates [7];
        int sent;
        rates = '{19'd44100, 19'd0, 19'd384000, 19'd1, 19'd8000, 19'd96000, 19'd48000};
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        instance_req = '0;
        mode         = '0;
        cutoff_hz    = '0;
        jitter_hz    = '0;
        gain         = '0;
        seed_key     = '0;
        out_stall    = 1'b0;
        mismatches   = 0;
        cycles       = 0;
        send_idle_pct = 33;
        recv_idle_pct = 56;
        rate_reg     = DEFAULT_RATE;
        for (int i = 0; i < INSTANCES; i++)
        begin
            inst_seeded[i] = 1'b0;
            stim_keys[i]   = $urandom;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_sample(dir_rows[i].inst, dir_rows[i].md, dir_rows[i].cut,
                        dir_rows[i].jit, dir_rows[i].g, dir_rows[i].key,
                        dir_rows[i].known, dir_rows[i].want);

        sent = 0;
        foreach (rates[r])
        begin
            wait_drained();
            write_rate(rates[r]);
            for (int i = 0; i < RANDOM_ITEMS / 7 + 1; i++)
            begin
                case (sent * 3 / RANDOM_ITEMS)
                    0: begin send_idle_pct = 33; recv_idle_pct = 56; end
                    1: begin send_idle_pct = 56; recv_idle_pct = 33; end
                    default: begin send_idle_pct = 0; recv_idle_pct = 0; end
                endcase
                // hold off once, after 50 items, until the pipe is empty
                if (sent == 50)
                    wait_drained();
                send_random();
                sent++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_samples.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
